// ----- sv/mvm_pkg.sv -----
// ----------------------------------------------------------------------------
// Matrix-vector multiply package
// Shared widths, command codes and the operation record passed from the
// front end through the queue to the compute back end.
// ----------------------------------------------------------------------------
package mvm_pkg;

  localparam int unsigned LANES       = 8;
  localparam int unsigned ELEM_W      = 32;
  localparam int unsigned MAX_COLS    = 1024;
  localparam int unsigned GROUPS      = MAX_COLS / LANES;
  localparam int unsigned GROUP_W     = $clog2(GROUPS);
  localparam int unsigned CFG_W       = 8;
  localparam int unsigned ROW_W       = 8;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int unsigned IN_DATA_W  = ((GROUP_W + LANES * ELEM_W + 7) / 8) * 8;
  localparam int unsigned IN_USER_W  = 1;
  localparam int unsigned OUT_DATA_W = ((ROW_W + ELEM_W + 7) / 8) * 8;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_ROW  = 1'b1
  } cmd_e;

  typedef logic [LANES-1:0][ELEM_W-1:0] lanes_t;

  typedef struct packed {
    cmd_e               cmd;
    logic               last;
    logic [GROUP_W-1:0] group;
    lanes_t             elems;
  } op_t;

endpackage

// ----- sv/mvm_front.sv -----
// ----------------------------------------------------------------------------
// Matrix-vector multiply front end
// Holds the group count register, unpacks input requests and marks the
// request that closes a row before it enters the queue.
// ----------------------------------------------------------------------------
module mvm_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mvm_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [mvm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [mvm_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                           op_valid_o,
  input  logic                           op_ready_i,
  output mvm_pkg::op_t                   op_o
);
  import mvm_pkg::*;

  logic [CFG_W-1:0]   groups_q;
  logic [GROUP_W-1:0] last_group;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      groups_q <= CFG_W'(GROUPS);
    end else if (cfg_valid_i) begin
      groups_q <= cfg_data_i;
    end
  end

  // A count of zero behaves as one group, counts above the store size clamp.
  always_comb begin
    priority if (groups_q == '0) begin
      last_group = '0;
    end else if (groups_q > CFG_W'(GROUPS)) begin
      last_group = GROUP_W'(GROUPS - 1);
    end else begin
      last_group = GROUP_W'(groups_q - 1'b1);
    end
  end

  always_comb begin
    op_o.cmd   = cmd_e'(s_axis_tuser[0]);
    op_o.group = s_axis_tdata[GROUP_W-1:0];
    op_o.last  = (s_axis_tdata[GROUP_W-1:0] == last_group);
    for (int l = 0; l < LANES; l++) begin
      op_o.elems[l] = s_axis_tdata[GROUP_W + l*ELEM_W +: ELEM_W];
    end
  end

  assign op_valid_o    = s_axis_tvalid;
  assign s_axis_tready = op_ready_i;

endmodule

// ----- sv/mvm_queue.sv -----
// ----------------------------------------------------------------------------
// Matrix-vector multiply request queue
// Short first-in first-out buffer that decouples the front end from the
// compute back end.
// ----------------------------------------------------------------------------
module mvm_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  mvm_pkg::op_t push_op_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output mvm_pkg::op_t pop_op_o
);
  import mvm_pkg::*;

  op_t               entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_op_o     = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

// ----- sv/mvm_back.sv -----
// ----------------------------------------------------------------------------
// Matrix-vector multiply back end
// Vector store, eight lane multipliers, adder tree, accumulator, row
// counter and the output register.
// ----------------------------------------------------------------------------
module mvm_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           op_valid_i,
  output logic                           op_ready_o,
  input  mvm_pkg::op_t                   op_i,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [mvm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import mvm_pkg::*;

  lanes_t              mem_q [GROUPS];
  lanes_t              rd_q;
  lanes_t              s1_elems_q;
  logic                s1_valid_q, s1_last_q, s1_first_q;
  lanes_t              prod_q;
  logic                s2_valid_q, s2_last_q, s2_first_q;
  logic [ELEM_W-1:0]   s3_lo_q, s3_hi_q;
  logic                s3_valid_q, s3_last_q, s3_first_q;
  logic [ELEM_W-1:0]   acc_q, acc_d, total;
  logic [ROW_W-1:0]    row_cnt_q, row_q;
  logic [ELEM_W-1:0]   dot_q;
  logic                out_valid_q;
  logic                adv, pop, emit;
  logic [ELEM_W-1:0]   prod_full [LANES];

  // The whole pipeline moves unless a finished result is still waiting.
  assign adv        = !out_valid_q || m_axis_tready;
  assign op_ready_o = adv;
  assign pop        = op_valid_i && adv;

  always_ff @(posedge clk_i) begin
    if (pop && op_i.cmd == CMD_LOAD) begin
      mem_q[op_i.group] <= op_i.elems;
    end
    if (adv) begin
      rd_q <= mem_q[op_i.group];
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      prod_full[l] = s1_elems_q[l] * rd_q[l];
    end
    total = s3_lo_q + s3_hi_q;
    acc_d = s3_first_q ? total : acc_q + total;
    emit  = s3_valid_q && s3_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      row_cnt_q   <= '0;
    end else if (adv) begin
      s1_valid_q  <= pop && (op_i.cmd == CMD_ROW);
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= emit;
      if (s3_valid_q) begin
        acc_q <= acc_d;
      end
      if (emit) begin
        row_cnt_q <= row_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_elems_q <= op_i.elems;
      s1_last_q  <= op_i.last;
      s1_first_q <= (op_i.group == '0);
      for (int l = 0; l < LANES; l++) begin
        prod_q[l] <= prod_full[l];
      end
      s2_last_q  <= s1_last_q;
      s2_first_q <= s1_first_q;
      s3_lo_q    <= (prod_q[0] + prod_q[1]) + (prod_q[2] + prod_q[3]);
      s3_hi_q    <= (prod_q[4] + prod_q[5]) + (prod_q[6] + prod_q[7]);
      s3_last_q  <= s2_last_q;
      s3_first_q <= s2_first_q;
      if (emit) begin
        row_q <= row_cnt_q;
        dot_q <= acc_d;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'({dot_q, row_q});

  a_stall_holds_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(acc_q))
    else $error("accumulator changed while the pipeline was stalled");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s3_valid_q && s3_last_q))
    else $error("result raised without a row-closing request");

  a_row_counter_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (row_cnt_q == ROW_W'(row_q + 1'b1)))
    else $error("row counter out of step with pending result");

endmodule

// ----- sv/matrix_vector_multiply_8lane.sv -----
// ----------------------------------------------------------------------------
// Eight-lane matrix-vector multiply
// Load requests fill the vector store, row requests are multiplied lane by
// lane, summed and accumulated; the last group of a row emits its result.
// ----------------------------------------------------------------------------
// A row-closing request accepted into an empty queue passes the queue entry,
// store read, multiply, tree and output registers before its result shows.
// Throughput: one request per cycle sustained; a stalled result holds the
// back-end pipeline and the four-entry queue then fills.
// Reset clears the accumulator, the row counter and the group count (128);
// the vector store is not cleared and must be loaded before use.
module matrix_vector_multiply_8lane (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mvm_pkg::CFG_W-1:0]      cfg_data_i,      // groups_in_use
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // group[6:0], v0[38:7], v1 .. v7 in 32-bit steps up to [262:231], pad bit 263
  input  logic [mvm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [mvm_pkg::IN_USER_W-1:0]  s_axis_tuser,    // cmd[0]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [mvm_pkg::OUT_DATA_W-1:0] m_axis_tdata     // row_index[7:0], dot_product[39:8]
);
  import mvm_pkg::*;

  op_t  front_op, queue_op;
  logic front_valid, front_ready;
  logic queue_valid, queue_ready;

  mvm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .op_valid_o    (front_valid),
    .op_ready_i    (front_ready),
    .op_o          (front_op)
  );

  mvm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_op_i    (front_op),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_op_o     (queue_op)
  );

  mvm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_valid_i    (queue_valid),
    .op_ready_o    (queue_ready),
    .op_i          (queue_op),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
